// ----- rtl/wfcm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Window to framebuffer coordinate map: shared package
// Widths, register indexes, mode codes and the setup sequencer states used by
// the top level, its datapath lane and the port checker.
// ----------------------------------------------------------------------------
package wfcm_pkg;

  // Width of every pointer field, in and out.
  localparam int VAL_W = 24;

  // Defaults for the top-level parameters.
  localparam int DIM_BITS_DEF  = 14;
  localparam int FRAC_BITS_DEF = 8;

  // Pipeline depth: capture, multiply, numerator, one stage per quotient bit,
  // and the output stage.
  localparam int NST = VAL_W + 4;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIN_W     = 3'd0,
    REG_WIN_H     = 3'd1,
    REG_FB_W      = 3'd2,
    REG_FB_H      = 3'd3,
    REG_ASPECT    = 3'd4,
    REG_INT_SCALE = 3'd5
  } cfg_reg_e;

  // Aspect mode codes.
  localparam logic [1:0] ASPECT_STRETCH = 2'd0;
  localparam logic [1:0] ASPECT_CROP    = 2'd1;

  // Setup sequencer run after every configuration write.
  typedef enum logic [2:0] {
    ST_RUN,
    ST_LOAD,
    ST_DIV,
    ST_CMP,
    ST_SEL,
    ST_OFS
  } setup_state_e;

endpackage

// ----- rtl/wfcm_lane.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Window to framebuffer coordinate map: one datapath lane
// Computes round(val * mul + off, den) with ties away from zero, saturated to
// the field width, through a multiply stage and a bit-per-stage divider.
// ----------------------------------------------------------------------------
module wfcm_lane import wfcm_pkg::*; #(
  parameter int DIM_BITS  = DIM_BITS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic [NST-1:0]                      en_i,
  input  logic signed [VAL_W-1:0]             val_i,
  input  logic [DIM_BITS:0]                   mul_i,
  input  logic [DIM_BITS:0]                   den_i,
  input  logic signed [2*DIM_BITS+FRAC_BITS:0] off_i,
  output logic signed [VAL_W-1:0]             val_o
);

  localparam int OW  = 2 * DIM_BITS + FRAC_BITS + 1;
  localparam int PW  = VAL_W + DIM_BITS + 2;
  localparam int NW  = ((PW > OW) ? PW : OW) + 1;
  localparam int NNW = NW + 2;
  localparam int HW  = NNW - VAL_W;
  localparam int RW  = DIM_BITS + 2;

  // Divisor of the rounding division: twice the denominator.
  logic [RW-1:0] div_e;
  assign div_e = {den_i, 1'b0};

  // Input capture.
  logic signed [VAL_W-1:0] val_q;
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      val_q <= val_i;
    end
  end

  // Scale multiply.
  logic signed [PW-1:0] prod_d, prod_q;
  assign prod_d = val_q * $signed({1'b0, mul_i});
  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      prod_q <= prod_d;
    end
  end

  // Add the centring offset, take the magnitude and form 2|n| + den.
  logic signed [NW-1:0] num;
  logic [NW-1:0]        mag;
  logic [NNW-1:0]       n_d, n_q;
  logic                 s2_q;
  always_comb begin
    num = NW'(prod_q) + NW'(off_i);
    mag = num[NW-1] ? NW'(-num) : NW'(num);
    n_d = NNW'({mag, 1'b0}) + NNW'(den_i);
  end
  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      n_q  <= n_d;
      s2_q <= num[NW-1];
    end
  end

  // Restoring divider, one quotient bit per stage. The bits above the quotient
  // range form the first partial remainder; if they reach the divisor the
  // quotient cannot fit and the result saturates.
  logic [HW-1:0]    rh;
  logic             sat0;
  assign rh   = n_q[NNW-1:VAL_W];
  assign sat0 = rh >= HW'(div_e);

  logic [RW-1:0]    r_q   [VAL_W];
  logic [VAL_W-1:0] lo_q  [VAL_W];
  logic [VAL_W-1:0] q_q   [VAL_W];
  logic             s_q   [VAL_W];
  logic             sat_q [VAL_W];

  for (genvar j = 0; j < VAL_W; j++) begin : g_div
    logic [RW-1:0]    r_in;
    logic [VAL_W-1:0] lo_in, q_in;
    logic             s_in, sat_in;
    logic [RW:0]      t;
    logic [RW:0]      t_sub;
    logic             ge;

    if (j == 0) begin : g_first
      assign r_in   = rh[RW-1:0];
      assign lo_in  = n_q[VAL_W-1:0];
      assign q_in   = '0;
      assign s_in   = s2_q;
      assign sat_in = sat0;
    end else begin : g_next
      assign r_in   = r_q[j-1];
      assign lo_in  = lo_q[j-1];
      assign q_in   = q_q[j-1];
      assign s_in   = s_q[j-1];
      assign sat_in = sat_q[j-1];
    end

    assign t     = {r_in, lo_in[VAL_W-1]};
    assign ge    = t >= {1'b0, div_e};
    assign t_sub = t - {1'b0, div_e};

    always_ff @(posedge clk_i) begin
      if (en_i[3+j]) begin
        r_q[j]   <= ge ? t_sub[RW-1:0] : t[RW-1:0];
        lo_q[j]  <= {lo_in[VAL_W-2:0], 1'b0};
        q_q[j]   <= {q_in[VAL_W-2:0], ge};
        s_q[j]   <= s_in;
        sat_q[j] <= sat_in;
      end
    end
  end

  // Apply the sign and saturate to the field range.
  localparam logic [VAL_W-1:0] MAX_V = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic [VAL_W-1:0] MIN_V = {1'b1, {(VAL_W-1){1'b0}}};
  logic [VAL_W-1:0] qf;
  logic [VAL_W-1:0] res_d;
  logic signed [VAL_W-1:0] out_q;
  always_comb begin
    qf = q_q[VAL_W-1];
    if (s_q[VAL_W-1]) begin
      if (sat_q[VAL_W-1] || (qf[VAL_W-1] && (|qf[VAL_W-2:0]))) begin
        res_d = MIN_V;
      end else begin
        res_d = VAL_W'(-qf);
      end
    end else begin
      if (sat_q[VAL_W-1] || qf[VAL_W-1]) begin
        res_d = MAX_V;
      end else begin
        res_d = qf;
      end
    end
  end
  always_ff @(posedge clk_i) begin
    if (en_i[NST-1]) begin
      out_q <= $signed(res_d);
    end
  end

  assign val_o = out_q;

endmodule

// ----- rtl/window_to_framebuffer_coord_map.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Window to framebuffer coordinate map
// Maps pointer position and motion from window pixels to framebuffer pixels,
// undoing a stretch, integer, crop or fit presentation scaler.
// ----------------------------------------------------------------------------
// Usage:
// Requests enter on in_valid_i / in_stall_o and leave on out_valid_o /
// out_stall_i; a request moves when valid is high and stall is low. The
// datapath is a 28-stage pipeline (capture, multiply, numerator, one stage
// per quotient bit of a 24-step divider, output); one request is taken
// every cycle unless a full stalled pipeline, a write or setup holds it.
// Registers are written on cfg_valid_i / cfg_ready_o. Each write starts a
// setup sequence (load, bit-serial division for the integer scale,
// compare, select, offset) that holds in_stall_o high until it ends;
// configuration is expected only while no request is in flight.
// Reset clears the registers, which selects passthrough, and empties the
// pipeline. When the receiver stalls, the output stage holds its result and
// empty stages behind it still fill, so the input stalls only once every
// stage holds a request.
// ----------------------------------------------------------------------------
module window_to_framebuffer_coord_map import wfcm_pkg::*; #(
  parameter int DIM_BITS  = DIM_BITS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [DIM_BITS-1:0]     cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic signed [VAL_W-1:0] pos_x_i,
  input  logic signed [VAL_W-1:0] pos_y_i,
  input  logic signed [VAL_W-1:0] delta_x_i,
  input  logic signed [VAL_W-1:0] delta_y_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [VAL_W-1:0] fb_x_o,
  output logic signed [VAL_W-1:0] fb_y_o,
  output logic signed [VAL_W-1:0] fb_delta_x_o,
  output logic signed [VAL_W-1:0] fb_delta_y_o
);

  localparam int OW = 2 * DIM_BITS + FRAC_BITS + 1;
  localparam int CW = $clog2(DIM_BITS + 1);

  // Configuration registers.
  logic [DIM_BITS-1:0] win_w_q, win_h_q, fb_w_q, fb_h_q;
  logic [1:0]          aspect_q;
  logic                int_scale_q;
  logic                cfg_we;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_w_q     <= '0;
      win_h_q     <= '0;
      fb_w_q      <= '0;
      fb_h_q      <= '0;
      aspect_q    <= ASPECT_STRETCH;
      int_scale_q <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index_i)
        REG_WIN_W:     win_w_q     <= cfg_data_i;
        REG_WIN_H:     win_h_q     <= cfg_data_i;
        REG_FB_W:      fb_w_q      <= cfg_data_i;
        REG_FB_H:      fb_h_q      <= cfg_data_i;
        REG_ASPECT:    aspect_q    <= cfg_data_i[1:0];
        REG_INT_SCALE: int_scale_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Setup sequencer state.
  setup_state_e state_q, state_d;
  logic [CW-1:0] cnt_q;
  logic          busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_RUN;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_RUN:  state_d = ST_RUN;
      ST_LOAD: state_d = ST_DIV;
      ST_DIV: begin
        if (cnt_q == CW'(DIM_BITS - 1)) begin
          state_d = ST_CMP;
        end
      end
      ST_CMP:  state_d = ST_SEL;
      ST_SEL:  state_d = ST_OFS;
      ST_OFS:  state_d = ST_RUN;
      default: state_d = ST_RUN;
    endcase
    if (cfg_we) begin
      state_d = ST_LOAD;
    end
  end

  assign busy = (state_q != ST_RUN);

  // Integer scale dividers: window size over framebuffer size, one bit a cycle.
  logic [DIM_BITS:0]   rx_q, ry_q;
  logic [DIM_BITS-1:0] qx_q, qy_q;
  logic [DIM_BITS:0]   tx, ty;
  logic                gex, gey;

  assign tx  = {rx_q[DIM_BITS-1:0], qx_q[DIM_BITS-1]};
  assign ty  = {ry_q[DIM_BITS-1:0], qy_q[DIM_BITS-1]};
  assign gex = tx >= {1'b0, fb_w_q};
  assign gey = ty >= {1'b0, fb_h_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (state_q == ST_LOAD) begin
      cnt_q <= '0;
    end else if (state_q == ST_DIV) begin
      cnt_q <= cnt_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_LOAD) begin
      rx_q <= '0;
      ry_q <= '0;
      qx_q <= win_w_q;
      qy_q <= win_h_q;
    end else if (state_q == ST_DIV) begin
      rx_q <= gex ? (tx - {1'b0, fb_w_q}) : tx;
      ry_q <= gey ? (ty - {1'b0, fb_h_q}) : ty;
      qx_q <= {qx_q[DIM_BITS-2:0], gex};
      qy_q <= {qy_q[DIM_BITS-2:0], gey};
    end
  end

  // Aspect comparison products.
  logic [2*DIM_BITS-1:0] p_wg_q, p_hf_q;
  always_ff @(posedge clk_i) begin
    if (state_q == ST_CMP) begin
      p_wg_q <= win_w_q * fb_h_q;
      p_hf_q <= win_h_q * fb_w_q;
    end
  end

  // Per-axis scale a/b and centring offsets.
  logic [DIM_BITS-1:0] ax_q, bx_q, ay_q, by_q;
  logic signed [OW-1:0] offx_q, offy_q;
  logic                zero;
  logic                wider, use_fw;
  logic [DIM_BITS-1:0] n_min;
  logic [2*DIM_BITS-1:0] fbx, wax, gby, hay;
  logic signed [2*DIM_BITS:0] dfx, dfy;

  assign zero   = (win_w_q == '0) || (win_h_q == '0) || (fb_w_q == '0) || (fb_h_q == '0);
  assign wider  = p_wg_q > p_hf_q;
  assign use_fw = (aspect_q == ASPECT_CROP) ? wider : !wider;
  assign n_min  = (qx_q < qy_q) ? qx_q : qy_q;
  assign fbx    = fb_w_q * bx_q;
  assign wax    = win_w_q * ax_q;
  assign gby    = fb_h_q * by_q;
  assign hay    = win_h_q * ay_q;
  assign dfx    = $signed({1'b0, fbx}) - $signed({1'b0, wax});
  assign dfy    = $signed({1'b0, gby}) - $signed({1'b0, hay});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ax_q   <= DIM_BITS'(1);
      bx_q   <= DIM_BITS'(1);
      ay_q   <= DIM_BITS'(1);
      by_q   <= DIM_BITS'(1);
      offx_q <= '0;
      offy_q <= '0;
    end else if (state_q == ST_SEL) begin
      if (zero) begin
        ax_q <= DIM_BITS'(1);
        bx_q <= DIM_BITS'(1);
        ay_q <= DIM_BITS'(1);
        by_q <= DIM_BITS'(1);
      end else if (aspect_q == ASPECT_STRETCH) begin
        ax_q <= fb_w_q;
        bx_q <= win_w_q;
        ay_q <= fb_h_q;
        by_q <= win_h_q;
      end else if (int_scale_q) begin
        ax_q <= DIM_BITS'(1);
        ay_q <= DIM_BITS'(1);
        bx_q <= (n_min == '0) ? DIM_BITS'(1) : n_min;
        by_q <= (n_min == '0) ? DIM_BITS'(1) : n_min;
      end else if (use_fw) begin
        ax_q <= fb_w_q;
        bx_q <= win_w_q;
        ay_q <= fb_w_q;
        by_q <= win_w_q;
      end else begin
        ax_q <= fb_h_q;
        bx_q <= win_h_q;
        ay_q <= fb_h_q;
        by_q <= win_h_q;
      end
    end else if (state_q == ST_OFS) begin
      offx_q <= zero ? '0 : $signed({dfx, {FRAC_BITS{1'b0}}});
      offy_q <= zero ? '0 : $signed({dfy, {FRAC_BITS{1'b0}}});
    end
  end

  // Pipeline valid bits and per-stage load enables; a stage loads when it is
  // empty or the stage after it moves on.
  logic [NST-1:0] v_q, rdy;
  logic           accept;

  always_comb begin
    rdy[NST-1] = !v_q[NST-1] || !out_stall_i;
    for (int k = NST - 2; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  assign in_stall_o = !rdy[0] || busy || cfg_valid_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NST; k++) begin
        if (rdy[k]) begin
          v_q[k] <= (k == 0) ? accept : v_q[k-1];
        end
      end
    end
  end

  assign out_valid_o = v_q[NST-1];

  // Four lanes: positions carry a doubled scale and the centring offset.
  wfcm_lane #(.DIM_BITS(DIM_BITS), .FRAC_BITS(FRAC_BITS)) u_lane_px (
    .clk_i (clk_i),
    .en_i  (rdy),
    .val_i (pos_x_i),
    .mul_i ({ax_q, 1'b0}),
    .den_i ({bx_q, 1'b0}),
    .off_i (offx_q),
    .val_o (fb_x_o)
  );

  wfcm_lane #(.DIM_BITS(DIM_BITS), .FRAC_BITS(FRAC_BITS)) u_lane_py (
    .clk_i (clk_i),
    .en_i  (rdy),
    .val_i (pos_y_i),
    .mul_i ({ay_q, 1'b0}),
    .den_i ({by_q, 1'b0}),
    .off_i (offy_q),
    .val_o (fb_y_o)
  );

  wfcm_lane #(.DIM_BITS(DIM_BITS), .FRAC_BITS(FRAC_BITS)) u_lane_dx (
    .clk_i (clk_i),
    .en_i  (rdy),
    .val_i (delta_x_i),
    .mul_i ({1'b0, ax_q}),
    .den_i ({1'b0, bx_q}),
    .off_i ('0),
    .val_o (fb_delta_x_o)
  );

  wfcm_lane #(.DIM_BITS(DIM_BITS), .FRAC_BITS(FRAC_BITS)) u_lane_dy (
    .clk_i (clk_i),
    .en_i  (rdy),
    .val_i (delta_y_i),
    .mul_i ({1'b0, ay_q}),
    .den_i ({1'b0, by_q}),
    .off_i ('0),
    .val_o (fb_delta_y_o)
  );

endmodule

// ----- rtl/wfcm_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Window to framebuffer coordinate map: port checker
// Watches the top-level ports for output holding and setup stalling.
// ----------------------------------------------------------------------------
module wfcm_port_assert import wfcm_pkg::*; (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    cfg_valid_i,
  input logic                    cfg_ready_o,
  input logic                    in_stall_o,
  input logic                    out_valid_o,
  input logic                    out_stall_i,
  input logic signed [VAL_W-1:0] fb_x_o,
  input logic signed [VAL_W-1:0] fb_y_o,
  input logic signed [VAL_W-1:0] fb_delta_x_o,
  input logic signed [VAL_W-1:0] fb_delta_y_o
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("stalled result withdrawn");

  // A stalled result keeps its value.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(fb_x_o) && $stable(fb_y_o) &&
      $stable(fb_delta_x_o) && $stable(fb_delta_y_o))
    else $error("stalled result changed");

  // No request is taken in the cycle of a register write.
  a_cfg_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> in_stall_o)
    else $error("request taken during register write");

  // The setup sequence after a write holds the input off.
  a_setup_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_ready_o |=> in_stall_o ##1 in_stall_o)
    else $error("request taken during setup");

endmodule

bind window_to_framebuffer_coord_map wfcm_port_assert u_wfcm_port_assert (.*);
